/* design/svdag_pkg.sv */
// Shared types and constants for the voxel DAG point query block.
`default_nettype none
package svdag_pkg;

    localparam int MAX_LEVELS  = 12;
    localparam int LEVEL_W     = 4;
    localparam int NODE_W      = 12;
    localparam int SLOT_W      = 3;
    localparam int ENTRY_W     = 16;
    localparam int COORD_W     = 36;
    localparam int SIDE_W      = 33;
    localparam int LEVEL_DEPTH = (1 << NODE_W) * 8;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Operation codes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Tree modes
    localparam logic [1:0] MODE_EMPTY  = 2'd0;
    localparam logic [1:0] MODE_MIRROR = 2'd3;

    // Config register indexes
    localparam logic [2:0] CFG_TREE_MODE   = 3'd0;
    localparam logic [2:0] CFG_TREE_LEVELS = 3'd1;
    localparam logic [2:0] CFG_BOX_MIN_X   = 3'd2;
    localparam logic [2:0] CFG_BOX_MIN_Y   = 3'd3;
    localparam logic [2:0] CFG_BOX_MIN_Z   = 3'd4;
    localparam logic [2:0] CFG_BOX_MAX_X   = 3'd5;
    localparam logic [2:0] CFG_BOX_MAX_Y   = 3'd6;
    localparam logic [2:0] CFG_BOX_MAX_Z   = 3'd7;

    typedef struct packed {
        logic               operation;
        logic [3:0]         level;
        logic [11:0]        node_index;
        logic [2:0]         child_slot;
        logic               child_present;
        logic [11:0]        child_pointer;
        logic [2:0]         mirror_bits;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic [3:0] reached_level;
        logic       missed;
    } t_out_item;

    // Slot write broadcast to every level cell
    typedef struct packed {
        logic               en;
        logic [LEVEL_W-1:0] level;
        logic [NODE_W-1:0]  node;
        logic [SLOT_W-1:0]  slot;
        logic [ENTRY_W-1:0] data;
    } t_wr;

    // Query state handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               missed;
        logic [LEVEL_W-1:0] lvl;
        logic [NODE_W-1:0]  node;
        logic [2:0]         mirror;
        t_coord             px;
        t_coord             py;
        t_coord             pz;
        t_coord             cx;
        t_coord             cy;
        t_coord             cz;
    } t_beat;

endpackage
`default_nettype wire

/* design/symmetric_voxel_dag_point_query.sv */
// Top level: config registers, query setup, chain of level cells, result buffer.
// Path of a query: the setup register at the accepting edge, 2 registers in each of
// the 12 level cells, the hold register and the output register.
// Flow: one query in flight; the next item is taken once the result has left
// the hold stage. A slot write is taken whenever no query is in flight.
// Reset: synchronous active low; config returns to defaults, the node store
// is not cleared and holds undefined data until written.
`default_nettype none
module symmetric_voxel_dag_point_query
    import svdag_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    logic [1:0]         r_mode;
    logic [3:0]         r_levels_cfg;
    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];

    logic               r_busy;
    logic               w_accept;
    logic               w_query;
    t_wr                w_wr;
    logic [LEVEL_W-1:0] w_levels;

    t_beat              n_beat0;
    logic [SIDE_W-1:0]  n_side;
    logic [SIDE_W-1:0]  r_side;
    logic               r_valid0;
    t_beat              r_beat0;

    logic               w_valid [MAX_LEVELS+1];
    t_beat              w_beat  [MAX_LEVELS+1];

    logic               r_hold_valid;
    t_out_item          r_hold;
    logic               w_move;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_EMPTY;
            r_levels_cfg <= 4'd12;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= '0;
                r_max[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TREE_MODE:   r_mode       <= i_cfg_data[1:0];
                CFG_TREE_LEVELS: r_levels_cfg <= i_cfg_data[3:0];
                CFG_BOX_MIN_X:   r_min[0]     <= i_cfg_data;
                CFG_BOX_MIN_Y:   r_min[1]     <= i_cfg_data;
                CFG_BOX_MIN_Z:   r_min[2]     <= i_cfg_data;
                CFG_BOX_MAX_X:   r_max[0]     <= i_cfg_data;
                CFG_BOX_MAX_Y:   r_max[1]     <= i_cfg_data;
                CFG_BOX_MAX_Z:   r_max[2]     <= i_cfg_data;
                default:         r_mode       <= r_mode;
            endcase
        end
    end

    assign w_levels = (r_levels_cfg > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : r_levels_cfg;

    // Input handshake
    assign o_in_stall = r_busy;
    assign w_accept   = i_in_valid && !r_busy;
    assign w_query    = w_accept && (t_op'(i_in_data.operation) == OP_QUERY);

    // Slot write beat
    always_comb begin
        w_wr.en    = w_accept && (t_op'(i_in_data.operation) == OP_WRITE);
        w_wr.level = i_in_data.level;
        w_wr.node  = i_in_data.node_index;
        w_wr.slot  = i_in_data.child_slot;
        w_wr.data  = {i_in_data.mirror_bits, i_in_data.child_pointer,
                      i_in_data.child_present};
    end

    // Query setup: box test, box centre and root side
    always_comb begin
        logic signed [31:0] pt [3];
        logic signed [32:0] sum;
        logic signed [32:0] dif;
        t_coord             cen [3];
        logic               outside;
        pt[0]   = i_in_data.point_x;
        pt[1]   = i_in_data.point_y;
        pt[2]   = i_in_data.point_z;
        outside = 1'b0;
        n_side  = '0;
        for (int a = 0; a < 3; a++) begin
            if (pt[a] < r_min[a] || pt[a] > r_max[a]) outside = 1'b1;
            sum    = 33'(r_min[a]) + 33'(r_max[a]);
            cen[a] = t_coord'(sum >>> 1);
            dif    = 33'(r_max[a]) - 33'(r_min[a]);
            if (dif > $signed({1'b0, n_side})) n_side = dif;
        end
        n_beat0.missed = outside || (r_mode == MODE_EMPTY);
        n_beat0.active = !n_beat0.missed;
        n_beat0.lvl    = '0;
        n_beat0.node   = '0;
        n_beat0.mirror = '0;
        n_beat0.px     = {{4{pt[0][31]}}, pt[0]};
        n_beat0.py     = {{4{pt[1][31]}}, pt[1]};
        n_beat0.pz     = {{4{pt[2][31]}}, pt[2]};
        n_beat0.cx     = cen[0];
        n_beat0.cy     = cen[1];
        n_beat0.cz     = cen[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else begin
            r_valid0 <= w_query;
        end
        if (w_query) begin
            r_beat0 <= n_beat0;
            r_side  <= n_side;
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_beat[0]  = r_beat0;

    // Chain of level cells
    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
        svdag_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cell_level(LEVEL_W'(g)),
            .i_levels    (w_levels),
            .i_mirror_en (r_mode == MODE_MIRROR),
            .i_side      (r_side),
            .i_wr        (w_wr),
            .i_valid     (w_valid[g]),
            .i_beat      (w_beat[g]),
            .o_valid     (w_valid[g+1]),
            .o_beat      (w_beat[g+1])
        );
    end

    // Hold stage and output register
    assign w_move = r_hold_valid && (!o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_hold_valid <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (w_query) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_valid[MAX_LEVELS]) begin
                r_hold_valid <= 1'b1;
            end else if (w_move) begin
                r_hold_valid <= 1'b0;
            end
            if (w_move) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
        if (w_valid[MAX_LEVELS]) begin
            r_hold.reached_level <= w_beat[MAX_LEVELS].lvl;
            r_hold.missed        <= w_beat[MAX_LEVELS].missed;
        end
        if (w_move) begin
            o_out_data <= r_hold;
        end
    end

endmodule
`default_nettype wire

/* design/svdag_ram.sv */
// Generic single write port RAM with registered read.
`default_nettype none
module svdag_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* design/svdag_cell.sv */
// One tree level: node store of that level and one descent step.
`default_nettype none
module svdag_cell
    import svdag_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [LEVEL_W-1:0] i_cell_level,
    input  wire logic [LEVEL_W-1:0] i_levels,
    input  wire logic               i_mirror_en,
    input  wire logic [SIDE_W-1:0]  i_side,
    input  wire t_wr                i_wr,
    input  wire logic               i_valid,
    input  wire t_beat              i_beat,
    output logic                    o_valid,
    output t_beat                   o_beat
);

    t_beat              n_a;
    t_beat              r_a;
    logic               r_a_valid;
    logic               r_a_go;
    logic               n_go;
    logic [ENTRY_W-1:0] w_rdata;
    logic [2:0]         w_slot;
    t_beat              n_b;
    t_coord             w_hs;
    logic               w_we;

    // Slot writes aimed at this level
    assign w_we = i_wr.en && (i_wr.level == i_cell_level);

    svdag_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(LEVEL_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr({i_wr.node, i_wr.slot}),
        .i_wdata(i_wr.data),
        .i_raddr({n_a.node, w_slot}),
        .o_rdata(w_rdata)
    );

    // Stage A: reflect the point, pick the octant, read the slot
    always_comb begin
        n_a  = i_beat;
        n_go = i_beat.active && (i_cell_level < i_levels);
        if (n_go && i_mirror_en) begin
            if (i_beat.mirror[0]) n_a.px = (i_beat.cx <<< 1) - i_beat.px;
            if (i_beat.mirror[1]) n_a.py = (i_beat.cy <<< 1) - i_beat.py;
            if (i_beat.mirror[2]) n_a.pz = (i_beat.cz <<< 1) - i_beat.pz;
        end
        w_slot = {n_a.px > n_a.cx, n_a.py > n_a.cy, n_a.pz > n_a.cz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a    <= n_a;
        r_a_go <= n_go;
    end

    // Half side of the child box
    assign w_hs = t_coord'({3'b000, i_side} >> (5'(i_cell_level) + 5'd2));

    // Stage B: follow the child or stop
    always_comb begin
        n_b = r_a;
        if (!r_a_go) begin
            n_b.active = 1'b0;
        end else if (!w_rdata[0]) begin
            n_b.active = 1'b0;
        end else begin
            n_b.lvl    = r_a.lvl + 4'd1;
            n_b.node   = w_rdata[12:1];
            n_b.mirror = w_rdata[15:13];
            n_b.cx     = (r_a.px > r_a.cx) ? r_a.cx + w_hs : r_a.cx - w_hs;
            n_b.cy     = (r_a.py > r_a.cy) ? r_a.cy + w_hs : r_a.cy - w_hs;
            n_b.cz     = (r_a.pz > r_a.cz) ? r_a.cz + w_hs : r_a.cz - w_hs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_a_valid;
        end
        o_beat <= n_b;
    end

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for symmetric_voxel_dag_point_query: slot writes and point queries against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import svdag_pkg::*;

    localparam logic [1:0] MODE_OCTREE = 2'd1;
    localparam logic [1:0] MODE_DAG    = 2'd2;
    localparam int NODES      = 4096;
    localparam int DRAIN_WAIT = 40;     // wait after the last result, longer than a query's path through the block
    localparam int STALL_LIMIT = 20000; // cycles with no beat on either channel

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;

    symmetric_voxel_dag_point_query u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Predictor copy of the configuration and the slot store
    logic [1:0]        cur_mode;
    logic [3:0]        cur_levels;
    longint            box_lo[3];
    longint            box_hi[3];
    logic [15:0]       slot_mem[int];
    t_out_item         lookup_q[$];

    int n_mismatch, n_fail, n_queries, n_writes, n_results, n_misses, n_deep;
    int idle_off;       // no sender/receiver gaps while set
    int hold_req;       // receiver long hold-off request
    int quiet_cycles;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Descend the tree; hole gets the first unwritten slot address touched, else -1
    function automatic void walk_point(input t_in_item it, output t_out_item r,
                                       output int hole);
        longint p[3], c[3];
        longint side, hs;
        int lvl, node, lim, addr;
        logic [2:0] mir, slot;
        logic [15:0] e;
        hole = -1;
        r.reached_level = '0;
        r.missed = 1'b1;
        p[0] = longint'(it.point_x);
        p[1] = longint'(it.point_y);
        p[2] = longint'(it.point_z);
        if (cur_mode == MODE_EMPTY) return;
        side = 0;
        for (int a = 0; a < 3; a++) begin
            if (p[a] < box_lo[a] || p[a] > box_hi[a]) return;
            c[a] = (box_lo[a] + box_hi[a]) >>> 1;
            if (box_hi[a] - box_lo[a] > side) side = box_hi[a] - box_lo[a];
        end
        lim = (cur_levels > MAX_LEVELS) ? MAX_LEVELS : cur_levels;
        lvl = 0;
        node = 0;
        mir = '0;
        while (lvl < lim) begin
            if (cur_mode == MODE_MIRROR)
                for (int a = 0; a < 3; a++)
                    if (mir[a]) p[a] = 2 * c[a] - p[a];
            slot = {p[0] > c[0], p[1] > c[1], p[2] > c[2]};
            addr = (lvl * NODES + node) * 8 + slot;
            if (!slot_mem.exists(addr)) begin
                hole = addr;
                return;
            end
            e = slot_mem[addr];
            if (!e[0]) break;
            lvl++;
            hs = side >>> (lvl + 1);
            for (int a = 0; a < 3; a++)
                c[a] += (p[a] > c[a]) ? hs : -hs;
            mir = e[15:13];
            node = e[12:1];
        end
        r.reached_level = lvl[3:0];
        r.missed = 1'b0;
    endfunction

    // Send one beat, update the predictor on acceptance
    task automatic send_beat(input t_in_item it);
        int gap;
        t_out_item r;
        int hole;
        gap = idle_off ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.operation == OP_WRITE) begin
            n_writes++;
            if (it.level < MAX_LEVELS)
                slot_mem[(int'(it.level) * NODES + int'(it.node_index)) * 8
                         + int'(it.child_slot)] =
                    {it.mirror_bits, it.child_pointer, it.child_present};
        end else begin
            n_queries++;
            walk_point(it, r, hole);
            lookup_q = {lookup_q, r};
            if (r.reached_level >= 8) n_deep++;
        end
    endtask

    task automatic write_slot(input int lvl, input int node, input int slot, input bit pres,
                              input int ptr, input int mir);
        t_in_item it;
        it = '0;
        it.operation     = OP_WRITE;
        it.level         = lvl[3:0];
        it.node_index    = node[11:0];
        it.child_slot    = slot[2:0];
        it.child_present = pres;
        it.child_pointer = ptr[11:0];
        it.mirror_bits   = mir[2:0];
        it.point_x       = $urandom;
        it.point_y       = $urandom;
        it.point_z       = $urandom;
        send_beat(it);
    endtask

    // Query a point, first filling any slot the descent would read unwritten
    task automatic query_point(input longint x, input longint y, input longint z);
        t_in_item it;
        t_out_item r;
        int hole;
        it = '0;
        it.operation = OP_QUERY;
        it.level = 4'($urandom);
        it.node_index = 12'($urandom);
        it.child_slot = 3'($urandom);
        it.child_present = 1'($urandom);
        it.child_pointer = 12'($urandom);
        it.mirror_bits = 3'($urandom);
        it.point_x = x[31:0];
        it.point_y = y[31:0];
        it.point_z = z[31:0];
        walk_point(it, r, hole);
        while (hole >= 0) begin
            write_slot(hole / (NODES * 8), (hole / 8) % NODES, hole % 8,
                       $urandom_range(0, 9) != 0,
                       ($urandom_range(0, 19) == 0) ? $urandom_range(0, NODES - 1)
                                                    : $urandom_range(0, 3),
                       $urandom_range(0, 7));
            walk_point(it, r, hole);
        end
        send_beat(it);
    endtask

    // Let everything in flight come out, then give the block time to settle
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_TREE_MODE:   cur_mode = val[1:0];
            CFG_TREE_LEVELS: cur_levels = val[3:0];
            CFG_BOX_MIN_X:   box_lo[0] = longint'(signed'(val));
            CFG_BOX_MIN_Y:   box_lo[1] = longint'(signed'(val));
            CFG_BOX_MIN_Z:   box_lo[2] = longint'(signed'(val));
            CFG_BOX_MAX_X:   box_hi[0] = longint'(signed'(val));
            CFG_BOX_MAX_Y:   box_hi[1] = longint'(signed'(val));
            default:         box_hi[2] = longint'(signed'(val));
        endcase
    endtask

    task automatic set_box(input longint lo, input longint hi);
        cfg_write(CFG_BOX_MIN_X, lo[31:0]);
        cfg_write(CFG_BOX_MIN_Y, lo[31:0]);
        cfg_write(CFG_BOX_MIN_Z, lo[31:0]);
        cfg_write(CFG_BOX_MAX_X, hi[31:0]);
        cfg_write(CFG_BOX_MAX_Y, hi[31:0]);
        cfg_write(CFG_BOX_MAX_Z, hi[31:0]);
    endtask

    function automatic longint pick_in(input int a);
        longint span;
        span = box_hi[a] - box_lo[a] + 1;
        if (span <= 0) return box_lo[a];
        return box_lo[a] + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic longint pick_coord(input int a);
        case ($urandom_range(0, 19))
            0: return box_lo[a] - 1;
            1: return box_hi[a] + 1;
            2: return box_lo[a];
            3: return box_hi[a];
            4: return longint'(signed'($urandom));
            default: return pick_in(a);
        endcase
    endfunction

    // Defaults after reset: empty tree, every query misses
    task automatic test_reset_defaults;
        query_point(0, 0, 0);
        query_point(-2147483648, 2147483647, 1);
        drain();
    endtask

    // Extremes, special cases and every operation
    task automatic test_directed;
        cfg_write(CFG_TREE_MODE, 32'(MODE_OCTREE));
        cfg_write(CFG_TREE_LEVELS, 12);
        set_box(-2147483648, 2147483647);
        query_point(-2147483648, -2147483648, -2147483648);
        query_point(2147483647, 2147483647, 2147483647);
        query_point(0, 0, 0);
        query_point(-1, -1, -1);
        // writes beyond the last level are dropped
        write_slot(12, 0, 0, 1'b1, 4095, 7);
        write_slot(15, 4095, 7, 1'b1, 0, 0);
        // pointer at the top of its range
        write_slot(11, 4095, 7, 1'b1, 4095, 7);
        query_point(2147483647, -2147483648, 12345);
        drain();
        // boundary points of a small box, inclusive test
        set_box(-65536, 65536);
        query_point(-65536, 65536, 0);
        query_point(-65537, 0, 0);
        query_point(0, 65537, 0);
        query_point(0, 0, -65537);
        drain();
        // zero levels and more levels than the store has
        cfg_write(CFG_TREE_LEVELS, 0);
        query_point(100, 200, 300);
        drain();
        cfg_write(CFG_TREE_LEVELS, 15);
        query_point(100, -200, 300);
        drain();
        // inverted box on one axis
        cfg_write(CFG_BOX_MIN_Y, 32'sd1000);
        cfg_write(CFG_BOX_MAX_Y, -32'sd1000);
        query_point(0, 0, 0);
        drain();
        // mirror mode and plain DAG on the same store
        set_box(-65536, 65536);
        cfg_write(CFG_TREE_MODE, 32'(MODE_MIRROR));
        query_point(30000, -30000, 5);
        query_point(-30000, 30000, -5);
        drain();
        cfg_write(CFG_TREE_MODE, 32'(MODE_DAG));
        query_point(30000, -30000, 5);
        drain();
    endtask

    // Random queries in one configuration, with some noise writes
    task automatic test_random_phase(input logic [1:0] mode, input int lvls, input int count);
        longint a, b, t;
        cfg_write(CFG_TREE_MODE, 32'(mode));
        cfg_write(CFG_TREE_LEVELS, lvls[31:0]);
        a = longint'(signed'($urandom));
        b = longint'(signed'($urandom));
        if ($urandom_range(0, 9) != 0 && a > b) begin
            t = a; a = b; b = t;
        end
        if ($urandom_range(0, 3) == 0) b = a + $urandom_range(0, 4096);
        if (b > 2147483647) b = 2147483647;
        set_box(a, b);
        idle_off = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0)
                write_slot($urandom_range(0, 15), $urandom_range(0, 4095),
                           $urandom_range(0, 7), $urandom_range(0, 1) != 0,
                           $urandom_range(0, 4095), $urandom_range(0, 7));
            else
                query_point(pick_coord(0), pick_coord(1), pick_coord(2));
        end
        idle_off = 0;
        drain();
    endtask

    // Receiver holds off long while queries keep coming
    task automatic test_backpressure;
        hold_req = 1;
        idle_off = 1;
        for (int i = 0; i < 30; i++)
            query_point(pick_in(0), pick_in(1), pick_in(2));
        idle_off = 0;
        drain();
    endtask

    // Receiver: random stall per result beat, plus the long hold-off
    initial begin
        int w;
        i_out_stall = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_req = 0;
                i_out_stall <= 1'b0;
            end else begin
                w = idle_off ? 0 : $urandom_range(0, 16);
                if (w > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (w) @(negedge i_clk);
                end
                i_out_stall <= 1'b0;
                @(posedge i_clk);
                while (!(o_out_valid && !i_out_stall) && !hold_req) @(posedge i_clk);
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lookup_q.size() == 0) begin
                n_fail++;
                if (n_mismatch++ < 10)
                    $display("unexpected result beat: level %0d missed %0d",
                             o_out_data.reached_level, o_out_data.missed);
            end else begin
                n_results++;
                if (lookup_q[0].missed) n_misses++;
                if (o_out_data.reached_level !== lookup_q[0].reached_level ||
                    o_out_data.missed !== lookup_q[0].missed) begin
                    n_fail++;
                    if (n_mismatch++ < 10)
                        $display("mismatch: expected level %0d missed %0d, got %0d %0d",
                                 lookup_q[0].reached_level, lookup_q[0].missed,
                                 o_out_data.reached_level, o_out_data.missed);
                end
                void'(lookup_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("symmetric_voxel_dag_point_query verification failed");
            $finish;
        end
    end

    initial begin
        n_mismatch = 0; n_fail = 0; n_queries = 0; n_writes = 0;
        n_results = 0; n_misses = 0; n_deep = 0;
        idle_off = 0; hold_req = 0; quiet_cycles = 0;
        cur_mode = MODE_EMPTY;
        cur_levels = 4'd12;
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = 0;
            box_hi[a] = 0;
        end
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_TREE_MODE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed();
        test_random_phase(MODE_OCTREE, 12, 250);
        test_random_phase(MODE_DAG, 12, 250);
        test_random_phase(MODE_MIRROR, 12, 300);
        test_random_phase(MODE_MIRROR, 1, 150);
        test_random_phase(MODE_OCTREE, 5, 150);
        test_random_phase(MODE_EMPTY, 12, 60);
        test_random_phase(MODE_DAG, 15, 150);
        test_random_phase(MODE_MIRROR, 0, 60);
        test_backpressure();
        test_random_phase(MODE_MIRROR, 12, 300);

        n_fail += lookup_q.size();
        $display("covered %0d queries (%0d misses, %0d reaching level 8 or deeper)",
                 n_queries, n_misses, n_deep);
        $display("and %0d slot writes over all tree modes and box settings; %0d mismatches",
                 n_writes, n_mismatch);
        if (n_fail == 0)
            $display("symmetric_voxel_dag_point_query verification clean");
        else
            $display("symmetric_voxel_dag_point_query verification failed");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
design/svdag_pkg.sv
design/svdag_ram.sv
design/svdag_cell.sv
design/symmetric_voxel_dag_point_query.sv
verif/tb.sv
